>>> hw/rtl/rasq_pkg.sv
// Package for the range-add / range-sum query engine.
// Holds table size, field widths, item codes, payload structs and clip_dist.
// No dependencies; every other file in hw/rtl imports it.
package rasq_pkg;

   localparam int MAX_UPDATES = 256;
   localparam int IDX_W = (MAX_UPDATES > 1) ? $clog2(MAX_UPDATES) : 1;
   localparam int CNT_W = $clog2(MAX_UPDATES + 1);
   localparam int KIND_W = 2;
   localparam int POS_W = 30;
   localparam int AMT_W = 32;
   localparam int DIFF_W = 32;
   localparam int SUM_W = 64;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        left_pos;
      logic [POS_W-1:0]        right_pos;
      logic signed [AMT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] range_sum;
      logic                    dropped;
   } rsp_type;

   // An item travelling down the cell row. For an update, tag is the slot it
   // lands in; for a query, tag is the number of updates it must see.
   typedef struct packed {
      logic                    vld;
      logic [KIND_W-1:0]       kind;
      logic [CNT_W-1:0]        tag;
      logic [POS_W-1:0]        left_pos;
      logic [POS_W-1:0]        right_pos;
      logic signed [AMT_W-1:0] amount;
      logic                    dropped;
      logic [SUM_W-1:0]        acc;
      logic [SUM_W-1:0]        prod;
   } item_type;

   // Distance by which x lies past a span edge, or zero.
   function automatic logic [POS_W-1:0] clip_dist(input logic [POS_W-1:0] x,
                                                  input logic [POS_W-1:0] edge_pos);
      logic [POS_W-1:0] gap;
      gap = (x > edge_pos) ? (x - edge_pos) : '0;
      return gap;
   endfunction

endpackage

>>> hw/rtl/rasq_cell.sv
// One cell of the update row: holds a single stored update and adds its
// share to each query whose tag exceeds cell_idx. Depends on rasq_pkg.
module rasq_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [rasq_pkg::IDX_W-1:0] cell_idx,
   input  rasq_pkg::item_type item_i,
   output rasq_pkg::item_type item_o
);
   import rasq_pkg::*;

   logic [POS_W-1:0]        start_ff;
   logic [POS_W-1:0]        end_ff;
   logic signed [AMT_W-1:0] amt_ff;

   item_type                item_ff;
   item_type                item_in;

   logic                    hit_add;
   logic                    use_entry;
   logic [POS_W-1:0]        rs_dist, re_dist, ls_dist, le_dist;
   logic signed [DIFF_W-1:0] span_diff;
   logic signed [SUM_W-1:0]  product;

   always_comb begin
      hit_add   = item_i.vld && (item_i.kind == KIND_ADD)
                  && (item_i.tag[IDX_W-1:0] == cell_idx);
      use_entry = item_i.vld && (item_i.kind == KIND_QUERY)
                  && (CNT_W'(cell_idx) < item_i.tag);

      rs_dist = clip_dist(item_i.right_pos, start_ff);
      re_dist = clip_dist(item_i.right_pos, end_ff);
      ls_dist = clip_dist(item_i.left_pos, start_ff);
      le_dist = clip_dist(item_i.left_pos, end_ff);
      // (P_r - P_l) weight of this update; always fits in 32 signed bits.
      span_diff = $signed(DIFF_W'(rs_dist) - DIFF_W'(re_dist)
                          - DIFF_W'(ls_dist) + DIFF_W'(le_dist));
      product   = SUM_W'(span_diff) * SUM_W'(amt_ff);

      item_in      = item_i;
      item_in.vld  = item_i.vld && !hit_add;
      item_in.acc  = item_i.acc + item_i.prod;
      item_in.prod = use_entry ? product : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.vld <= 1'b0;
      end else if (advance) begin
         item_ff.vld <= item_in.vld;
      end
      if (advance) begin
         item_ff.kind      <= item_in.kind;
         item_ff.tag       <= item_in.tag;
         item_ff.left_pos  <= item_in.left_pos;
         item_ff.right_pos <= item_in.right_pos;
         item_ff.amount    <= item_in.amount;
         item_ff.dropped   <= item_in.dropped;
         item_ff.acc       <= item_in.acc;
         item_ff.prod      <= item_in.prod;
         if (hit_add) begin
            start_ff <= item_i.left_pos;
            end_ff   <= item_i.right_pos;
            amt_ff   <= item_i.amount;
         end
      end
   end

   assign item_o = item_ff;

endmodule

>>> hw/rtl/rasq_tail.sv
// Output stage of the cell row: folds in the last partial product and holds
// the query result until it is taken. Depends on rasq_pkg.
module rasq_tail (
   input  logic               clock,
   input  logic               reset,
   input  rasq_pkg::item_type item_i,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rasq_pkg::rsp_type  rsp_data
);
   import rasq_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      advance                = !rsp_valid_ff || rsp_ready;
      rsp_valid_in           = item_i.vld && (item_i.kind == KIND_QUERY);
      rsp_data_in.range_sum  = $signed(item_i.acc + item_i.prod);
      rsp_data_in.dropped    = item_i.dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/range_add_range_sum_query_top.sv
// Top level of the range-add / range-sum query engine.
// Instantiates the cell row (rasq_cell) and the output stage (rasq_tail); uses rasq_pkg.
//
// The engine keeps up to MAX_UPDATES range-add updates in a row of cells, one
// update per cell. Every item enters the row at cell 0 and moves one cell per
// cycle. An update lands in the cell whose number equals the fill count at the
// time it was accepted; a query carries the fill count it saw and collects, in
// every cell below that count, the product of the stored amount and the span
// weight, so the sum it reaches at the end of the row covers exactly the
// updates accepted before it. On its way out, a query passes through the
// register of every cell, starting at cell 0, then the output register. Items
// move in order, so while no result is stalled the row takes one item per
// cycle, and a result follows every cycle once the row is full of queries.
// A clear and a dropped update never enter the row: both act only on the
// fill count and the sticky drop flag here at the head, at once, so a query
// accepted right after a clear already sees an empty table. Items with the
// unused kind code are taken and ignored. The row moves only while the
// output register is empty or being read, so a stalled result holds every
// item in place and req_ready falls with it. The table needs no clearing
// pass after reset.
module range_add_range_sum_query_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rasq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rasq_pkg::rsp_type rsp_data
);
   import rasq_pkg::*;

   logic             advance;
   logic             accept;
   logic             table_full;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             overflow_ff;
   logic             overflow_in;

   // Cell output registers, plus the combinational head item in entry 0.
   item_type         chain [0:MAX_UPDATES];

   assign req_ready  = advance;
   assign accept     = req_valid && req_ready;
   assign table_full = (count_ff == CNT_W'(MAX_UPDATES));

   // Fill count and sticky drop flag.
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         case (req_data.kind)
            KIND_ADD: begin
               if (table_full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // Head item: only queries and updates that fit go down the row.
   always_comb begin
      chain[0].vld       = accept && ((req_data.kind == KIND_QUERY)
                           || ((req_data.kind == KIND_ADD) && !table_full));
      chain[0].kind      = req_data.kind;
      chain[0].tag       = count_ff;
      chain[0].left_pos  = req_data.left_pos;
      chain[0].right_pos = req_data.right_pos;
      chain[0].amount    = req_data.amount;
      chain[0].dropped   = overflow_ff;
      chain[0].acc       = '0;
      chain[0].prod      = '0;
   end

   for (genvar gi = 0; gi < MAX_UPDATES; gi++) begin : g_cell
      rasq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_idx (IDX_W'(gi)),
         .item_i   (chain[gi]),
         .item_o   (chain[gi+1])
      );
   end

   rasq_tail u_tail (
      .clock     (clock),
      .reset     (reset),
      .item_i    (chain[MAX_UPDATES]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the range-add / range-sum query engine.
// It drives update, query and clear items into range_add_range_sum_query_top
// and checks every query result against its own span table; it uses rasq_pkg.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rasq_pkg::*;

   // Kind code 3 has no meaning. The block must take such an item and ignore it.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [POS_W-1:0]  POS_MAX     = '1;

   // After the last result we wait as long as a query spends in the cell row,
   // plus some margin, so that any result the block should not have produced
   // still shows up.
   localparam int ROW_LATENCY  = MAX_UPDATES;
   localparam int TAIL_CYCLES  = ROW_LATENCY + 50;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 400;

   // Modes of the result-side stall pattern.
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_e;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   range_add_range_sum_query_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // The 20 ns clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Items waiting to be driven, and query results waiting to be seen.
   req_type pending_items[$];
   rsp_type expected_sums[$];

   // The testbench's own copy of the update table. Only entries below
   // tbl_count are read, so entries that were never written are never used.
   logic [POS_W-1:0]        tbl_start  [MAX_UPDATES];
   logic [POS_W-1:0]        tbl_end    [MAX_UPDATES];
   logic signed [AMT_W-1:0] tbl_amount [MAX_UPDATES];
   int unsigned             tbl_count   = 0;
   logic                    tbl_dropped = 1'b0;

   int          n_total     = 0;  // every item queued, unused kinds included
   int          n_random    = 0;  // random items that do real work
   int          n_accepted  = 0;
   int          n_adds      = 0;
   int          n_drops     = 0;
   int          n_queries   = 0;
   int          n_checked   = 0;
   int          n_errors    = 0;
   int unsigned cycle_count = 0;

   // Handshake state of the sender and of the stalling receiver.
   logic        req_taken        = 1'b0;
   int          gap_left         = 0;
   int          burst_left       = 8;
   ready_mode_e ready_mode       = READY_ALWAYS;
   int          ready_phase_left = 0;

   // Weighted distance to x from the table: the sum over all stored updates
   // of amount * (cells of [start, end) below x), where a reversed span
   // counts negatively. Everything wraps at 64 bits.
   function automatic logic [SUM_W-1:0] prefix_sum_at(input logic [POS_W-1:0] x);
      logic [SUM_W-1:0] total;
      logic [SUM_W-1:0] past_start;
      logic [SUM_W-1:0] past_end;
      logic [SUM_W-1:0] amt_wide;
      int               i;
      total = '0;
      for (i = 0; i < tbl_count; i++) begin
         past_start = (x > tbl_start[i]) ? SUM_W'(x - tbl_start[i]) : '0;
         past_end   = (x > tbl_end[i])   ? SUM_W'(x - tbl_end[i])   : '0;
         amt_wide   = {{(SUM_W-AMT_W){tbl_amount[i][AMT_W-1]}}, tbl_amount[i]};
         total      = total + amt_wide * (past_start - past_end);
      end
      return total;
   endfunction

   // Applies one accepted item to the table; a query records its expected result.
   task automatic record_item(input req_type item);
      rsp_type want;
      case (item.kind)
         KIND_ADD: begin
            n_adds++;
            if (tbl_count >= MAX_UPDATES) begin
               tbl_dropped = 1'b1;
               n_drops++;
            end else begin
               tbl_start[tbl_count]  = item.left_pos;
               tbl_end[tbl_count]    = item.right_pos;
               tbl_amount[tbl_count] = item.amount;
               tbl_count++;
            end
         end
         KIND_QUERY: begin
            want.range_sum = prefix_sum_at(item.right_pos) - prefix_sum_at(item.left_pos);
            want.dropped   = tbl_dropped;
            expected_sums  = {expected_sums, want};
            n_queries++;
         end
         KIND_CLEAR: begin
            tbl_count   = 0;
            tbl_dropped = 1'b0;
         end
         default: begin
         end
      endcase
   endtask

   // Compares one accepted result with the oldest expected one.
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_sums.size() == 0) begin
         $display("%0t: result with no query waiting: range_sum %h dropped %b",
                  $time, got.range_sum, got.dropped);
         n_errors++;
      end else begin
         want = expected_sums.pop_front();
         n_checked++;
         if (got.range_sum !== want.range_sum) begin
            $display("%0t: range_sum mismatch: expected %h actual %h",
                     $time, want.range_sum, got.range_sum);
            n_errors++;
         end
         if (got.dropped !== want.dropped) begin
            $display("%0t: dropped mismatch: expected %b actual %b",
                     $time, want.dropped, got.dropped);
            n_errors++;
         end
      end
   endtask

   task automatic queue_item(input logic [KIND_W-1:0]       kind,
                             input logic [POS_W-1:0]        left_pos,
                             input logic [POS_W-1:0]        right_pos,
                             input logic signed [AMT_W-1:0] amount);
      req_type item;
      item.kind      = kind;
      item.left_pos  = left_pos;
      item.right_pos = right_pos;
      item.amount    = amount;
      pending_items  = {pending_items, item};
      n_total++;
      if (kind != KIND_UNUSED) n_random++;
   endtask

   // Half of the coordinates lie near a per-sequence base so that spans overlap in
   // small, checkable ways; the rest are the extremes or fully random.
   function automatic logic [POS_W-1:0] pick_pos(input logic [POS_W-1:0] base);
      logic [POS_W-1:0] pos;
      case ($urandom_range(0, 9))
         0:       pos = '0;
         1:       pos = POS_MAX;
         2, 3, 4: pos = POS_W'($urandom);
         default: pos = base + POS_W'($urandom_range(0, 64));
      endcase
      return pos;
   endfunction

   function automatic logic signed [AMT_W-1:0] pick_amount();
      logic signed [AMT_W-1:0] amt;
      case ($urandom_range(0, 7))
         0:       amt = 32'sh7fffffff;
         1:       amt = 32'sh80000000;
         2, 3:    amt = AMT_W'($urandom);
         default: amt = AMT_W'($urandom_range(0, 200)) - 100;
      endcase
      return amt;
   endfunction

   // Sample side. Everything is taken at the rising edge: accepted items update
   // the table, accepted results are checked. A result comes only after its
   // query has crossed the whole cell row, so the order of the two is immaterial.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            n_accepted++;
            record_item(req_data);
         end
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   // Sender. It changes its outputs only at the falling edge. A held item
   // stays on the bus until the edge that accepts it. Items go out in bursts
   // of random length, and a random gap follows each burst. About a quarter
   // of the gaps are zero, so that long stretches run without any idling.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_items.size() > 0) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Each phase of random length uses one stall mode: always ready,
   // a coin toss per cycle, a fixed five-in-eight pattern, or ready only now
   // and then. Stalls back up the whole cell row, so they reach the sender too.
   always @(negedge clock) begin
      if (ready_phase_left == 0) begin
         ready_mode       <= ready_mode_e'($urandom_range(0, 3));
         ready_phase_left <= $urandom_range(20, 300);
      end else begin
         ready_phase_left <= ready_phase_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_ready <= (cycle_count % 8) < 5;
         default:        rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(negedge clock);
      $display("%0t: timeout after %0d cycles, %0d results still waiting",
               $time, cycle_count, expected_sums.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [POS_W-1:0] base;
      int               len;
      int               roll;
      int               j;
      bit               fill_done;

      // Directed items. The first query runs on an empty table. Then come the
      // extremes of coordinates and amounts, a reversed update, an empty
      // update, reversed, empty and point queries, and an unused kind that
      // must change nothing. After a clear the table reads empty again. The
      // two most negative amounts over the widest span give a sum of nearly -2^62.
      queue_item(KIND_QUERY,  '0,      POS_MAX, '0);
      queue_item(KIND_ADD,    '0,      POS_MAX, 32'sh7fffffff);
      queue_item(KIND_ADD,    POS_MAX, '0,      32'sh80000000);
      queue_item(KIND_ADD,    30'd5,   30'd5,   32'sd1234);
      queue_item(KIND_ADD,    30'd100, 30'd200, -32'sd1);
      queue_item(KIND_QUERY,  '0,      POS_MAX, '0);
      queue_item(KIND_QUERY,  POS_MAX, '0,      '0);
      queue_item(KIND_QUERY,  30'd150, 30'd150, '0);
      queue_item(KIND_QUERY,  '0,      30'd1,   '0);
      queue_item(KIND_QUERY,  30'd150, 30'd250, 32'sh7fffffff);
      queue_item(KIND_UNUSED, POS_MAX, POS_MAX, -32'sd1);
      queue_item(KIND_UNUSED, '0,      '0,      '0);
      queue_item(KIND_QUERY,  '0,      POS_MAX, '0);
      queue_item(KIND_CLEAR,  POS_MAX, '0,      32'sh80000000);
      queue_item(KIND_QUERY,  '0,      POS_MAX, '0);
      queue_item(KIND_ADD,    '0,      POS_MAX, 32'sh80000000);
      queue_item(KIND_ADD,    '0,      POS_MAX, 32'sh80000000);
      queue_item(KIND_QUERY,  '0,      POS_MAX, '0);
      queue_item(KIND_QUERY,  30'd1,   POS_MAX - 30'd1, '0);
      queue_item(KIND_QUERY,  POS_MAX - 30'd1, 30'd1, '0);
      queue_item(KIND_CLEAR,  '0,      '0,      '0);
      queue_item(KIND_QUERY,  30'd10,  30'd20,  '0);

      // Random part, built from short sequences of updates and queries around
      // a common base, with a few clears and unused kinds as noise. One
      // sequence fills the table past its capacity. Its last updates are
      // dropped, the queries after them must report the drop, and the clear
      // that ends the sequence must cancel it.
      n_random  = 0;
      fill_done = 1'b0;
      while (n_random < RANDOM_ITEMS) begin
         base = POS_W'($urandom);
         if (!fill_done && n_random >= 60) begin
            fill_done = 1'b1;
            queue_item(KIND_CLEAR, pick_pos(base), pick_pos(base), pick_amount());
            for (j = 0; j < MAX_UPDATES + 6; j++) begin
               queue_item(KIND_ADD, pick_pos(base), pick_pos(base), pick_amount());
               if ($urandom_range(0, 31) == 0)
                  queue_item(KIND_QUERY, pick_pos(base), pick_pos(base), pick_amount());
            end
            repeat (4) queue_item(KIND_QUERY, pick_pos(base), pick_pos(base), pick_amount());
            queue_item(KIND_CLEAR, pick_pos(base), pick_pos(base), pick_amount());
            queue_item(KIND_QUERY, pick_pos(base), pick_pos(base), pick_amount());
         end else begin
            if ($urandom_range(0, 3) == 0)
               queue_item(KIND_CLEAR, pick_pos(base), pick_pos(base), pick_amount());
            len = $urandom_range(5, 40);
            for (j = 0; j < len; j++) begin
               roll = $urandom_range(0, 99);
               if (roll < 55)
                  queue_item(KIND_ADD, pick_pos(base), pick_pos(base), pick_amount());
               else if (roll < 93)
                  queue_item(KIND_QUERY, pick_pos(base), pick_pos(base), pick_amount());
               else if (roll < 97)
                  queue_item(KIND_UNUSED, pick_pos(base), pick_pos(base), pick_amount());
               else
                  queue_item(KIND_CLEAR, pick_pos(base), pick_pos(base), pick_amount());
            end
         end
      end

      // Reset is held from the start and released at a falling edge.
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // These counters and queues change only at rising edges. Reading them
      // at falling edges therefore avoids any race with the sample side.
      while (n_accepted != n_total) @(negedge clock);
      while (expected_sums.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d items: %0d updates (%0d dropped on a full table), %0d queries.",
               n_total, n_adds, n_drops, n_queries);
      $display("Checked %0d query results, found %0d mismatches.", n_checked, n_errors);
      if (n_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
